/* src/pths_pkg.sv */
// package for the periodic task heap scheduler
// holds the key widths and the command, status and state codes; no dependencies
`default_nettype none
package pths_pkg;
  localparam int unsigned IdW = 12;
  localparam int unsigned TimeW = 32;
  localparam int unsigned KeyW = TimeW + IdW;

  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_NEXT     = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_TOP_RD,
    S_PER_RD,
    S_PER_WAIT,
    S_DN_RD,
    S_DN_CMP,
    S_DN_SEL,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

/* src/periodic_task_heap_scheduler.sv */
// periodic task heap scheduler: min-heap of {due time, id} and period table in two memories
// register sifts the new entry up from the last slot; next reads the root and its task's
// period, then sifts the root down with its advanced due time; the heap memory has a
// single read port, and a full or empty request returns its error status directly
// one request at a time: a new request is taken only when idle and no result is pending
// reset clears heap count and control; memory contents stay undefined; uses pths_pkg
`default_nettype none
module periodic_task_heap_scheduler #(
  parameter int unsigned HEAP_CAPACITY = 1024,
  parameter int unsigned TASK_ID_COUNT = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // task_id[11:0], period[23:12]
  input  wire logic        s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // due_task[11:0], due_time[43:12]
  output logic [1:0]       m_axis_tuser   // status
);
  import pths_pkg::*;

  localparam int unsigned AW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
  localparam int unsigned CW = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned TW = (TASK_ID_COUNT > 1) ? $clog2(TASK_ID_COUNT) : 1;
  localparam int unsigned PW = AW + 1;

  logic [KeyW-1:0] heap_mem [HEAP_CAPACITY];
  logic [IdW-1:0]  per_mem  [TASK_ID_COUNT];

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] pos_q, pos_d, child_q, child_d;
  logic [KeyW-1:0] item_q, item_d, cand_q, cand_d;
  logic [IdW-1:0] id_q, id_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [1:0] status_q, status_d;
  logic out_v_q, out_v_d;

  logic h_we, h_re, p_we, p_re;
  logic [AW-1:0] h_waddr, h_raddr;
  logic [KeyW-1:0] h_wdata, h_rdata;
  logic [TW-1:0] p_addr;
  logic [IdW-1:0] p_rdata;

  always_ff @(posedge clk_i) begin
    if (h_we) heap_mem[h_waddr] <= h_wdata;
    if (h_re) h_rdata <= heap_mem[h_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) per_mem[p_addr] <= s_axis_tdata[23:12];
    if (p_re) p_rdata <= per_mem[p_addr];
  end

  logic [TimeW:0] sum;
  logic [PW-1:0] parent;
  assign parent = (pos_q - PW'(1)) >> 1;
  assign sum = {1'b0, time_q} + {{(TimeW-IdW+1){1'b0}}, p_rdata};

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d = pos_q;
    child_d = child_q;
    item_d = item_q;
    cand_d = cand_q;
    id_d = id_q;
    time_d = time_q;
    status_d = status_q;
    out_v_d = out_v_q;
    h_we = 1'b0; h_re = 1'b0; p_we = 1'b0; p_re = 1'b0;
    h_waddr = pos_q[AW-1:0];
    h_raddr = parent[AW-1:0];
    h_wdata = item_q;
    p_addr = TW'(s_axis_tdata[IdW-1:0]);
    if (out_v_q && m_axis_tready) out_v_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && !out_v_q) begin
          id_d = '0; time_d = '0; status_d = ST_OK;
          if (s_axis_tuser == CMD_REGISTER) begin
            if (CW'(HEAP_CAPACITY) <= count_q) begin
              status_d = ST_FULL; state_d = S_DONE;
            end else begin
              p_we = 1'b1;
              item_d = {20'd0, s_axis_tdata[23:12], s_axis_tdata[11:0]};
              pos_d = PW'(count_q);
              count_d = count_q + CW'(1);
              state_d = S_UP_RD;
            end
          end else if (count_q == '0) begin
            status_d = ST_EMPTY; state_d = S_DONE;
          end else begin
            h_re = 1'b1; h_raddr = '0;
            state_d = S_TOP_RD;
          end
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          h_we = 1'b1; state_d = S_DONE;
        end else begin
          h_re = 1'b1; state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (h_rdata <= item_q) begin
          h_we = 1'b1; state_d = S_DONE;
        end else begin
          h_we = 1'b1; h_wdata = h_rdata;
          pos_d = parent; state_d = S_UP_RD;
        end
      end
      S_TOP_RD: begin
        id_d = h_rdata[IdW-1:0];
        time_d = h_rdata[KeyW-1:IdW];
        state_d = S_PER_RD;
      end
      S_PER_RD: begin
        p_re = 1'b1; p_addr = TW'(id_q);
        state_d = S_PER_WAIT;
      end
      S_PER_WAIT: begin
        item_d = {(sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0]), id_q};
        pos_d = '0;
        state_d = S_DN_RD;
      end
      S_DN_RD: begin
        // read left child
        child_d = {pos_q[PW-2:0], 1'b1};
        if ({1'b0, pos_q[PW-2:0], 1'b1} >= (PW+1)'(count_q)) begin
          h_we = 1'b1; state_d = S_DONE;
        end else begin
          h_re = 1'b1; h_raddr = child_d[AW-1:0];
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cand_d = h_rdata;
        if ((PW+1)'(child_q) + (PW+1)'(1) < (PW+1)'(count_q)) begin
          h_re = 1'b1; h_raddr = child_q[AW-1:0] + AW'(1);
          state_d = S_DN_SEL;
        end else if (item_q <= h_rdata) begin
          h_we = 1'b1; state_d = S_DONE;
        end else begin
          h_we = 1'b1; h_wdata = h_rdata; pos_d = child_q; state_d = S_DN_RD;
        end
      end
      S_DN_SEL: begin
        if (h_rdata < cand_q) begin
          if (item_q <= h_rdata) begin
            h_we = 1'b1; state_d = S_DONE;
          end else begin
            h_we = 1'b1; h_wdata = h_rdata;
            pos_d = child_q + PW'(1); state_d = S_DN_RD;
          end
        end else if (item_q <= cand_q) begin
          h_we = 1'b1; state_d = S_DONE;
        end else begin
          h_we = 1'b1; h_wdata = cand_q; pos_d = child_q; state_d = S_DN_RD;
        end
      end
      S_DONE: begin
        out_v_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    child_q <= child_d;
    item_q <= item_d;
    cand_q <= cand_d;
    id_q <= id_d;
    time_q <= time_d;
    status_q <= status_d;
  end

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {4'b0000, time_q, id_q};
  assign m_axis_tuser = status_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(HEAP_CAPACITY)) else $error("heap count overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready with pending result");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> m_axis_tvalid) else $error("result lost");
  a_full_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == ST_FULL) |-> $stable(count_q))
    else $error("count changed on full");
`endif
endmodule
`default_nettype wire

/* test/tb.sv */
// testbench for periodic_task_heap_scheduler: drives register and next requests,
// predicts the heap in a scoreboard class and checks every result; uses pths_pkg
`timescale 1ns / 100ps
module tb;
  import pths_pkg::*;

  localparam int Capacity = 1024;
  localparam int IdCount = 4096;

  typedef struct {
    status_e     status;
    logic [11:0] due_task;
    logic [31:0] due_time;
  } reminder_t;

  class reminder_board;
    logic [43:0] heap[Capacity];
    int          count;
    logic [11:0] periods[IdCount];
    reminder_t   pending[$];
    int          errors;

    function void note_request(cmd_e cmd, logic [11:0] id, logic [11:0] per);
      reminder_t   r;
      logic [43:0] item;
      logic [31:0] t;
      logic [32:0] sum;
      int          pos;
      int          child;
      r.status = ST_OK;
      r.due_task = '0;
      r.due_time = '0;
      if (cmd == CMD_REGISTER) begin
        if (count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          periods[id % IdCount] = per;
          item = {20'd0, per, id};
          pos = count;
          count++;
          while (pos > 0 && heap[(pos - 1) / 2] > item) begin
            heap[pos] = heap[(pos - 1) / 2];
            pos = (pos - 1) / 2;
          end
          heap[pos] = item;
        end
      end else if (count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.due_task = heap[0][11:0];
        t = heap[0][43:12];
        r.due_time = t;
        sum = {1'b0, t} + periods[r.due_task % IdCount];
        // advanced time saturates
        item = {sum[32] ? 32'hFFFF_FFFF : sum[31:0], r.due_task};
        pos = 0;
        forever begin
          child = 2 * pos + 1;
          if (child >= count) break;
          if (child + 1 < count && heap[child + 1] < heap[child]) child++;
          if (item <= heap[child]) break;
          heap[pos] = heap[child];
          pos = child;
        end
        heap[pos] = item;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [47:0] data, logic [1:0] user);
      reminder_t r;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h %h", user, data);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (user !== r.status) begin
        $error("status expected %0d got %0d", r.status, user);
        errors++;
      end
      if (data[11:0] !== r.due_task) begin
        $error("due_task expected %0d got %0d", r.due_task, data[11:0]);
        errors++;
      end
      if (data[43:12] !== r.due_time) begin
        $error("due_time expected %0d got %0d", r.due_time, data[43:12]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // task_id[11:0], period[23:12]
  logic        s_axis_tuser = 1'b0;  // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;  // due_task[11:0], due_time[43:12]
  logic [1:0]  m_axis_tuser;  // status

  reminder_board board = new();
  int  send_idle;
  int  recv_idle;
  bit  hold_go;
  int  hold_left;

  periodic_task_heap_scheduler u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver side: checks results, stalls at random or for a long hold-off
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_request(cmd_e cmd, logic [11:0] id, logic [11:0] per);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {per, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(cmd, id, per);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_request();
    logic [11:0] id;
    id = ($urandom_range(3) == 0) ? 12'($urandom_range(15)) : 12'($urandom);
    if ($urandom_range(99) < 55) begin
      send_request(CMD_REGISTER, id,
                   ($urandom_range(3) == 0) ? 12'($urandom_range(3)) : 12'($urandom));
    end else begin
      send_request(CMD_NEXT, 12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    send_idle = 0;
    recv_idle = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty heap, zero period, extremes, ties, duplicate ids
    send_request(CMD_NEXT, 12'hFFF, 12'hFFF);
    send_request(CMD_REGISTER, 12'd0, 12'd0);
    send_request(CMD_NEXT, 12'd0, 12'd0);
    send_request(CMD_NEXT, 12'd0, 12'd0);
    send_request(CMD_REGISTER, 12'hFFF, 12'hFFF);
    send_request(CMD_REGISTER, 12'd7, 12'd10);
    send_request(CMD_REGISTER, 12'd3, 12'd10);
    send_request(CMD_REGISTER, 12'd5, 12'd4);
    send_request(CMD_REGISTER, 12'd5, 12'd9);
    send_request(CMD_REGISTER, 12'hAAA, 12'h555);
    send_request(CMD_REGISTER, 12'h555, 12'hAAA);
    repeat (12) send_request(CMD_NEXT, 12'd0, 12'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 37 : (phase == 1) ? 63 : 0;
      recv_idle = (phase == 0) ? 63 : (phase == 1) ? 37 : 0;
      if (phase == 2) hold_go = 1'b1;
      repeat (200) random_request();
      drain();
    end

    repeat (30) random_request();
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
